### hw/rtl/hd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hd_pkg: haversine distance shared definitions
// Fixed-point formats, cordic and square root cell types, arithmetic helpers.
// ----------------------------------------------------------------------------
package hd_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int CORDIC_STAGES   = 24;
    localparam int SQRT_DIGITS     = 31;
    localparam int DW              = 34;
    localparam int RAD_SHIFT       = ANGLE_FRAC_BITS + 6;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [30:0] DEG2RAD_Q36 =
        31'(((PI_Q60 / 64'd180) + (64'd1 << 23)) >> 24);

    localparam logic signed [DW-1:0] ONE_Q30  = DW'(64'd1 << 30);
    localparam logic signed [DW-1:0] GAIN_Q30 = DW'(64'd652032874);

    localparam logic signed [26:0] FULL_DEG = 27'(360 * (2 ** ANGLE_FRAC_BITS));
    localparam logic signed [26:0] HALF_DEG = 27'(180 * (2 ** ANGLE_FRAC_BITS));
    localparam logic [23:0] DEG_90  = 24'(90 * (2 ** ANGLE_FRAC_BITS));
    localparam logic [23:0] DEG_180 = 24'(180 * (2 ** ANGLE_FRAC_BITS));

    localparam logic [15:0] RADIUS_RESET = 16'd6371;
    localparam logic [26:0] TWO_KM_M     = 27'd2000;

    localparam logic signed [DW-1:0] ATAN_SMALL [11] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
        34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
        34'sd4194283,   34'sd2097149,   34'sd1048575
    };

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
    } t_cordic;

    typedef struct packed {
        logic [61:0] rad;
        logic [31:0] rem;
        logic [30:0] root;
    } t_sqrt;

    function automatic logic signed [DW-1:0] atan_step(input int i);
        if (i < 11) begin
            return ATAN_SMALL[i];
        end else if (i <= 30) begin
            return DW'(64'd1 << (30 - i));
        end else begin
            return '0;
        end
    endfunction

    // reduce a degree difference into [-180, 180] and return its magnitude
    function automatic logic [23:0] wrap_mag(input logic signed [26:0] d);
        logic signed [26:0] r;
        r = d;
        if (r >= FULL_DEG) begin
            r = r - FULL_DEG;
        end else if (r <= -FULL_DEG) begin
            r = r + FULL_DEG;
        end
        if (r > HALF_DEG) begin
            r = r - FULL_DEG;
        end else if (r < -HALF_DEG) begin
            r = r + FULL_DEG;
        end
        if (r[26]) begin
            r = -r;
        end
        return r[23:0];
    endfunction

    function automatic logic signed [DW-1:0] deg_to_rad(input logic [23:0] mag,
                                                        input logic halve);
        logic [55:0] p;
        logic [55:0] r;
        p = 56'(mag) * 56'(DEG2RAD_Q36);
        if (halve) begin
            r = (p + (56'd1 << RAD_SHIFT)) >> (RAD_SHIFT + 1);
        end else begin
            r = (p + (56'd1 << (RAD_SHIFT - 1))) >> RAD_SHIFT;
        end
        return DW'(r);
    endfunction

    // q30 product, rounded half away from zero
    function automatic logic signed [DW-1:0] mulq(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        logic [DW-1:0] ma;
        logic [DW-1:0] mb;
        logic [2*DW-1:0] p;
        logic [DW-1:0] r;
        ma = a[DW-1] ? (~a + DW'(1)) : a;
        mb = b[DW-1] ? (~b + DW'(1)) : b;
        p  = (2*DW)'(ma) * (2*DW)'(mb) + ((2*DW)'(1) << 29);
        r  = p[DW+29:30];
        return (a[DW-1] ^ b[DW-1]) ? $signed(~r + DW'(1)) : $signed(r);
    endfunction

endpackage

### hw/rtl/hd_pair_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hd_pair_if: point pair channel
// Valid/ready channel carrying two points in fixed-point degrees.
// ----------------------------------------------------------------------------
interface hd_pair_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] lat_a;
    logic signed [24:0] lon_a;
    logic signed [23:0] lat_b;
    logic signed [24:0] lon_b;

    modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
    modport sink   (input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

### hw/rtl/hd_dist_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hd_dist_if: distance channel
// Valid/ready channel carrying one distance in metres.
// ----------------------------------------------------------------------------
interface hd_dist_if;
    logic        valid;
    logic        ready;
    logic [28:0] distance_m;

    modport source (output valid, distance_m, input ready);
    modport sink   (input valid, distance_m, output ready);
endinterface

### hw/rtl/hd_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hd_cfg_if: radius write channel
// Valid/ready channel carrying the sphere radius in kilometres.
// ----------------------------------------------------------------------------
interface hd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] earth_radius_km;

    modport source (output valid, earth_radius_km, input ready);
    modport sink   (input valid, earth_radius_km, output ready);
endinterface

### hw/rtl/hd_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hd_cordic_cell: one cordic micro-rotation
// Rotation or vectoring step for a fixed stage index, registered.
// ----------------------------------------------------------------------------
module hd_cordic_cell #(
    parameter int   INDEX  = 0,
    parameter logic VECTOR = 1'b0
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  hd_pkg::t_cordic  i_d,
    output hd_pkg::t_cordic  o_d
);
    localparam logic signed [hd_pkg::DW-1:0] ANG = hd_pkg::atan_step(INDEX);

    hd_pkg::t_cordic r_d;
    hd_pkg::t_cordic n_d;
    logic signed [hd_pkg::DW-1:0] xs;
    logic signed [hd_pkg::DW-1:0] ys;
    logic ccw;

    always_comb begin
        xs  = $signed(i_d.x) >>> INDEX;
        ys  = $signed(i_d.y) >>> INDEX;
        ccw = VECTOR ? i_d.y[hd_pkg::DW-1] : !i_d.z[hd_pkg::DW-1];
        if (ccw) begin
            n_d.x = i_d.x - ys;
            n_d.y = i_d.y + xs;
            n_d.z = i_d.z - ANG;
        end else begin
            n_d.x = i_d.x + ys;
            n_d.y = i_d.y - xs;
            n_d.z = i_d.z + ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

### hw/rtl/hd_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hd_sqrt_cell: one digit of the integer square root
// Restoring step that settles one root bit per cell, registered.
// ----------------------------------------------------------------------------
module hd_sqrt_cell (
    input  logic           i_clk,
    input  logic           i_en,
    input  hd_pkg::t_sqrt  i_d,
    output hd_pkg::t_sqrt  o_d
);
    hd_pkg::t_sqrt r_d;
    hd_pkg::t_sqrt n_d;
    logic [33:0] cur;
    logic [33:0] trial;

    always_comb begin
        cur     = {i_d.rem, i_d.rad[61:60]};
        trial   = {1'b0, i_d.root, 2'b01};
        n_d.rad = {i_d.rad[59:0], 2'b00};
        if (cur >= trial) begin
            n_d.rem  = 32'(cur - trial);
            n_d.root = {i_d.root[29:0], 1'b1};
        end else begin
            n_d.rem  = cur[31:0];
            n_d.root = {i_d.root[29:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

### hw/rtl/haversine_distance_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_distance_top: great-circle distance between two points
// Each point pair passes the front, radian, sine/cosine, product, root and vectoring stages.
// Throughput one point pair per cycle while the skid entry is empty, set by the cordic and root cell chains.
// A held result plus one skid entry absorb output stalls before input stalls.
// Synchronous active-low reset clears valid state and sets radius to 6371 km.
// ----------------------------------------------------------------------------
module haversine_distance_top #(
    parameter int CORDIC_STAGES = hd_pkg::CORDIC_STAGES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hd_pair_if.sink    i_pair,
    hd_dist_if.source  o_dist,
    hd_cfg_if.sink     i_cfg
);
    localparam int DW    = hd_pkg::DW;
    localparam int ND    = hd_pkg::SQRT_DIGITS;
    localparam int DEPTH = 5 + 2 * CORDIC_STAGES + ND;

    logic en;
    logic acc;
    logic [DEPTH-1:0] r_vld;

    logic [26:0] r_rad2k;

    // front stage
    logic [23:0] n_mag [4];
    logic [23:0] r_mag [4];
    logic        n_neg;
    logic        r_neg0;
    logic [23:0] cma;
    logic [23:0] cmb;
    logic        fa;
    logic        fb;

    // radian stage
    logic signed [DW-1:0] r_z [4];
    logic                 r_neg1;

    hd_pkg::t_cordic w_rot [4][CORDIC_STAGES+1];
    logic [CORDIC_STAGES-1:0] r_negd;

    logic signed [DW-1:0] r_sa;
    logic signed [DW-1:0] r_sb;
    logic signed [DW-1:0] r_cc;
    logic signed [DW-1:0] r_sa2;
    logic signed [DW-1:0] r_t;
    logic signed [DW-1:0] cc;
    logic signed [DW:0]   h;
    logic [30:0] r_h;
    logic [30:0] r_hc;

    hd_pkg::t_sqrt   w_sy [ND+1];
    hd_pkg::t_sqrt   w_sx [ND+1];
    hd_pkg::t_cordic w_at [CORDIC_STAGES+1];

    logic [30:0] ang;
    logic [58:0] prod;
    logic [28:0] n_dist;

    logic        r_out_valid;
    logic [28:0] r_out_dist;
    logic        r_skid_valid;
    logic [28:0] r_skid_dist;
    logic        take;
    logic        incoming;

    assign en           = !r_skid_valid;
    assign i_pair.ready = en;
    assign acc          = i_pair.valid && en;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rad2k <= 27'(hd_pkg::RADIUS_RESET) * hd_pkg::TWO_KM_M;
        end else if (i_cfg.valid) begin
            r_rad2k <= 27'(i_cfg.earth_radius_km) * hd_pkg::TWO_KM_M;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], acc};
        end
    end

    // angle differences and cosine folding
    always_comb begin
        n_mag[0] = hd_pkg::wrap_mag(27'(i_pair.lat_a) - 27'(i_pair.lat_b));
        n_mag[1] = hd_pkg::wrap_mag(27'(i_pair.lon_a) - 27'(i_pair.lon_b));
        cma = i_pair.lat_a[23] ? 24'(-i_pair.lat_a) : 24'(i_pair.lat_a);
        cmb = i_pair.lat_b[23] ? 24'(-i_pair.lat_b) : 24'(i_pair.lat_b);
        fa  = cma > hd_pkg::DEG_90;
        fb  = cmb > hd_pkg::DEG_90;
        n_mag[2] = fa ? (hd_pkg::DEG_180 - cma) : cma;
        n_mag[3] = fb ? (hd_pkg::DEG_180 - cmb) : cmb;
        n_neg    = fa ^ fb;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mag  <= n_mag;
            r_neg0 <= n_neg;
            r_z[0] <= hd_pkg::deg_to_rad(r_mag[0], 1'b1);
            r_z[1] <= hd_pkg::deg_to_rad(r_mag[1], 1'b1);
            r_z[2] <= hd_pkg::deg_to_rad(r_mag[2], 1'b0);
            r_z[3] <= hd_pkg::deg_to_rad(r_mag[3], 1'b0);
            r_neg1 <= r_neg0;
            r_negd <= {r_negd[CORDIC_STAGES-2:0], r_neg1};
        end
    end

    // sine and cosine rows
    for (genvar l = 0; l < 4; l++) begin : g_lane
        assign w_rot[l][0] = '{x: hd_pkg::GAIN_Q30, y: '0, z: r_z[l]};
        for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
            hd_cordic_cell #(.INDEX(s), .VECTOR(1'b0)) u_cell (
                .i_clk (i_clk),
                .i_en  (en),
                .i_d   (w_rot[l][s]),
                .o_d   (w_rot[l][s+1])
            );
        end
    end

    always_comb begin
        cc = hd_pkg::mulq(w_rot[2][CORDIC_STAGES].x, w_rot[3][CORDIC_STAGES].x);
        if (r_negd[CORDIC_STAGES-1]) begin
            cc = -cc;
        end
        h = (DW+1)'(r_sa2) + (DW+1)'(r_t);
        if (h[DW]) begin
            h = '0;
        end else if (h > (DW+1)'(hd_pkg::ONE_Q30)) begin
            h = (DW+1)'(hd_pkg::ONE_Q30);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sa  <= hd_pkg::mulq(w_rot[0][CORDIC_STAGES].y, w_rot[0][CORDIC_STAGES].y);
            r_sb  <= hd_pkg::mulq(w_rot[1][CORDIC_STAGES].y, w_rot[1][CORDIC_STAGES].y);
            r_cc  <= cc;
            r_sa2 <= r_sa;
            r_t   <= hd_pkg::mulq(r_cc, r_sb);
            r_h   <= h[30:0];
            r_hc  <= 31'(hd_pkg::ONE_Q30) - h[30:0];
        end
    end

    // square roots of h and 1-h
    assign w_sy[0] = '{rad: {1'b0, r_h, 30'd0}, rem: '0, root: '0};
    assign w_sx[0] = '{rad: {1'b0, r_hc, 30'd0}, rem: '0, root: '0};

    for (genvar d = 0; d < ND; d++) begin : g_root
        hd_sqrt_cell u_sy (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (w_sy[d]),
            .o_d   (w_sy[d+1])
        );
        hd_sqrt_cell u_sx (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (w_sx[d]),
            .o_d   (w_sx[d+1])
        );
    end

    // central half-angle by vectoring
    assign w_at[0] = '{x: DW'(w_sx[ND].root), y: DW'(w_sy[ND].root), z: '0};

    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_atan
        hd_cordic_cell #(.INDEX(s), .VECTOR(1'b1)) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (w_at[s]),
            .o_d   (w_at[s+1])
        );
    end

    always_comb begin
        ang    = w_at[CORDIC_STAGES].z[DW-1] ? '0 : w_at[CORDIC_STAGES].z[30:0];
        prod   = 59'(ang) * 59'(r_rad2k) + (59'd1 << 29);
        n_dist = prod[58:30];
    end

    // output register with skid entry
    assign take     = r_out_valid && o_dist.ready;
    assign incoming = en && r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (incoming) begin
            if (r_out_valid && !take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out_dist <= r_skid_dist;
            end
        end else if (incoming) begin
            if (r_out_valid && !take) begin
                r_skid_dist <= n_dist;
            end else begin
                r_out_dist <= n_dist;
            end
        end
    end

    assign o_dist.valid      = r_out_valid;
    assign o_dist.distance_m = r_out_dist;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without a result in the output register");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_vld[0])
        else $error("accepted beat not tracked in the first stage");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !o_dist.ready))
        else $error("skid entry filled while the output was free");

endmodule
